### hw/rtl/gctl_pkg.sv
// shared types, constants and the arctangent table of the track length core
`default_nettype none

package gctl_pkg;

    localparam int ANGLE_FRAC_BITS_DEF  = 29;
    localparam int LENGTH_FRAC_BITS_DEF = 8;

    localparam logic [23:0] RADIUS_RESET = 24'd6371109;

    localparam int ANG_W         = 34;
    localparam int CX_W          = 49;
    localparam int CZ_W          = 36;
    localparam int CORDIC_STEPS  = 32;
    localparam int CORDIC_GUARD  = 16;
    localparam int CNT_W         = $clog2(CORDIC_STEPS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI32     = (PI_Q60 + (64'd1 << 27)) >> 28;
    localparam logic [63:0] HALF32   = PI32 >> 1;
    localparam logic [63:0] GAIN_Q30 = 64'd652032874;
    localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

    typedef logic [CORDIC_STEPS-1:0][31:0] atan_tab_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] lat_a;
        logic signed [ANG_W-1:0] lat_b;
        logic signed [ANG_W-1:0] dlat_half;
        logic signed [ANG_W-1:0] dlon_half;
        logic                    has_seg;
        logic                    first;
        logic                    last;
    } gctl_entry_t;

    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] atan_q32(input int i);
        logic signed [63:0] acc;
        logic        [63:0] term;
        int                 sh;
        acc = '0;
        if (i == 0)
        begin
            acc = signed'(PI_Q60);
        end
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                sh = i * (2 * k + 1);
                if (sh <= 62)
                begin
                    term = cdiv(64'd1 << (62 - sh), 64'(2 * k + 1));
                    if ((k & 1) != 0)
                        acc = acc - signed'(term);
                    else
                        acc = acc + signed'(term);
                end
            end
        end
        return 32'((acc + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic atan_tab_t atan_table();
        atan_tab_t t;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            t[i] = atan_q32(i);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gctl_front.sv
// front end: holds the previous point, scales and clamps angles, reduces the longitude step
`default_nettype none

module gctl_front #(
    parameter int ANGLE_FRAC_BITS = gctl_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic signed [30:0]    lat_rad,
    input  wire logic signed [31:0]    lon_rad,
    input  wire logic                  track_start,
    input  wire logic                  track_end,
    input  wire logic                  q_full,
    output logic                       q_push,
    output gctl_pkg::gctl_entry_t      q_entry
);
    import gctl_pkg::*;

    localparam int SC        = 32 - ANGLE_FRAC_BITS;
    localparam int DW        = 33 + SC;
    localparam int TW        = DW + 1;
    localparam int SH        = TW - 34;
    localparam int RW        = TW + 1;
    localparam int EW        = RW + 1;
    localparam int RED_STEPS = SH + 2;
    localparam int RC_W      = $clog2(RED_STEPS + 1);

    localparam logic signed [EW-1:0] HALF_E   = EW'(HALF32);
    localparam logic signed [EW-1:0] OFF_E    = EW'(PI32 << SH);
    localparam logic        [RW-1:0] DIV_INIT = RW'(PI32 << (SH + 1));

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RED  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic signed [30:0]       prev_lat_reg;
    logic signed [31:0]       prev_lon_reg;
    logic                     have_prev_reg;
    logic signed [ANG_W-1:0]  la_reg, lb_reg, dh_reg;
    logic [RW-1:0]            rem_reg, div_reg;
    logic [RC_W-1:0]          cnt_reg;
    logic                     seg_reg, first_reg, last_reg;

    logic                     accept;
    logic signed [EW-1:0]     la_e, lb_e, la_c, lb_c, dlat, dh_e;
    logic signed [EW-1:0]     lona_e, lonb_e, dlon, ph_e, t_e, phi_e;

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;

    assign la_e = EW'(prev_lat_reg) <<< SC;
    assign lb_e = EW'(lat_rad) <<< SC;
    assign la_c = (la_e > HALF_E) ? HALF_E : ((la_e < -HALF_E) ? -HALF_E : la_e);
    assign lb_c = (lb_e > HALF_E) ? HALF_E : ((lb_e < -HALF_E) ? -HALF_E : lb_e);
    assign dlat = lb_c - la_c;
    assign dh_e = (dlat >>> 1) + EW'(dlat[EW-1] & dlat[0]);

    assign lona_e = EW'(prev_lon_reg) <<< SC;
    assign lonb_e = EW'(lon_rad) <<< SC;
    assign dlon   = lonb_e - lona_e;
    assign ph_e   = (dlon >>> 1) + EW'(dlon[EW-1] & dlon[0]);
    assign t_e    = ph_e + HALF_E + OFF_E;
    assign phi_e  = signed'(EW'(rem_reg)) - HALF_E;

    assign q_push            = (state_reg == F_PUSH) && !q_full;
    assign q_entry.lat_a     = la_reg;
    assign q_entry.lat_b     = lb_reg;
    assign q_entry.dlat_half = dh_reg;
    assign q_entry.dlon_half = phi_e[ANG_W-1:0];
    assign q_entry.has_seg   = seg_reg;
    assign q_entry.first     = first_reg;
    assign q_entry.last      = last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_RED;
            end
            F_RED:
            begin
                if (cnt_reg == RC_W'(RED_STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                prev_lat_reg  <= lat_rad;
                prev_lon_reg  <= lon_rad;
                have_prev_reg <= !track_end;
                cnt_reg       <= '0;
            end
            else if (state_reg == F_RED)
            begin
                cnt_reg <= cnt_reg + RC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            la_reg    <= la_c[ANG_W-1:0];
            lb_reg    <= lb_c[ANG_W-1:0];
            dh_reg    <= dh_e[ANG_W-1:0];
            rem_reg   <= t_e[RW-1:0];
            div_reg   <= DIV_INIT;
            seg_reg   <= have_prev_reg && !track_start;
            first_reg <= track_start;
            last_reg  <= track_end;
        end
        else if (state_reg == F_RED)
        begin
            if (rem_reg >= div_reg)
                rem_reg <= rem_reg - div_reg;
            div_reg <= div_reg >> 1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gctl_queue.sv
// short queue of classified points between the front end and the back end
`default_nettype none

module gctl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_push,
    output logic                       q_full,
    input  gctl_pkg::gctl_entry_t      wr_entry,
    input  wire logic                  q_pop,
    output logic                       q_empty,
    output gctl_pkg::gctl_entry_t      rd_entry
);
    import gctl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    gctl_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign q_full   = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (q_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (q_push && !q_pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (q_pop && !q_push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

`default_nettype wire

### hw/rtl/gctl_cordic.sv
// shared iterative cordic, rotation or vectoring, one micro-rotation per cycle
`default_nettype none

module gctl_cordic (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            vec_mode,
    input  wire logic signed [gctl_pkg::ANG_W-1:0] angle,
    input  wire logic [30:0]                     vx,
    input  wire logic [30:0]                     vy,
    output logic                                 done,
    output logic signed [gctl_pkg::CX_W-1:0]     x_out,
    output logic signed [gctl_pkg::CX_W-1:0]     y_out,
    output logic signed [gctl_pkg::CZ_W-1:0]     z_out
);
    import gctl_pkg::*;

    localparam atan_tab_t ATAN = atan_table();
    localparam logic signed [CX_W-1:0] X0 = CX_W'(GAIN_Q30 << CORDIC_GUARD);

    logic                    busy_reg, done_reg, mode_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [CX_W-1:0]  x_reg, y_reg;
    logic signed [CZ_W-1:0]  z_reg;

    logic signed [CX_W-1:0]  xs, ys;
    logic signed [CZ_W-1:0]  t;
    logic                    dir_pos;

    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign t       = signed'(CZ_W'(ATAN[cnt_reg]));
    assign dir_pos = mode_reg ? !(y_reg > 0) : (z_reg >= 0);

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= vec_mode;
            x_reg    <= vec_mode ? CX_W'({vx, 16'b0}) : X0;
            y_reg    <= vec_mode ? CX_W'({vy, 16'b0}) : '0;
            z_reg    <= vec_mode ? '0 : CZ_W'(angle);
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gctl_back.sv
// back end: sequencer over cordic, square root and multiplier, running sum and result register
`default_nettype none

module gctl_back #(
    parameter int LENGTH_FRAC_BITS = gctl_pkg::LENGTH_FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    input  gctl_pkg::gctl_entry_t      q_entry,
    input  wire logic                  cfg_we,
    input  wire logic [23:0]           cfg_wdata,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [47:0]                total_length,
    output logic                       saturated
);
    import gctl_pkg::*;

    localparam int SH_OUT = 32 - LENGTH_FRAC_BITS;
    localparam logic [61:0] RND   = 62'd1 << (31 - LENGTH_FRAC_BITS);
    localparam logic [61:0] ONE60 = 62'd1 << 60;
    localparam logic signed [CX_W-1:0] ONE_X = CX_W'(64'd1 << 30);
    localparam logic signed [CX_W-1:0] HRND  = CX_W'(64'd1 << (CORDIC_GUARD - 1));

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CORD_GO  = 5'd1;
    localparam logic [4:0] S_CORD_WT  = 5'd2;
    localparam logic [4:0] S_MUL_CC   = 5'd3;
    localparam logic [4:0] S_SQ_LOAD  = 5'd4;
    localparam logic [4:0] S_SQ_RUN   = 5'd5;
    localparam logic [4:0] S_MUL_V    = 5'd6;
    localparam logic [4:0] S_V        = 5'd7;
    localparam logic [4:0] S_MUL_S1   = 5'd8;
    localparam logic [4:0] S_MUL_VV   = 5'd9;
    localparam logic [4:0] S_H_SUM    = 5'd10;
    localparam logic [4:0] S_VEC_GO   = 5'd11;
    localparam logic [4:0] S_VEC_WT   = 5'd12;
    localparam logic [4:0] S_MUL_AH   = 5'd13;
    localparam logic [4:0] S_MUL_AL   = 5'd14;
    localparam logic [4:0] S_PROD     = 5'd15;
    localparam logic [4:0] S_ACC      = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;

    localparam logic [1:0] SQ_G = 2'd0;
    localparam logic [1:0] SQ_M = 2'd1;
    localparam logic [1:0] SQ_W = 2'd2;

    logic [4:0]              state_reg, state_next;
    gctl_entry_t             ent_reg;
    logic [1:0]              cidx_reg, sq_sel_reg;
    logic [30:0]             ca_reg, cb_reg, g_reg, m_reg, w_reg;
    logic signed [31:0]      s1_reg, s2_reg, v_reg;
    logic [61:0]             h_reg, prod_reg;
    logic [35:0]             ang_reg;
    logic signed [65:0]      p_reg;
    logic [47:0]             sum_reg;
    logic                    sat_reg;
    logic [23:0]             radius_reg;
    logic                    out_valid_reg, out_sat_reg;
    logic [47:0]             out_total_reg;
    logic [61:0]             sq_val_reg;
    logic [32:0]             sq_rem_reg;
    logic [30:0]             sq_root_reg;
    logic [CNT_W-1:0]        sq_cnt_reg;

    logic                    c_start, c_vec, c_done;
    logic signed [ANG_W-1:0] c_angle;
    logic signed [CX_W-1:0]  c_x, c_y, xr, yr;
    logic signed [CZ_W-1:0]  c_z;
    logic signed [CZ_W:0]    z2;
    logic [30:0]             cos_c;
    logic signed [31:0]      sin_c;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      vq;
    logic [61:0]             h_sum;
    logic [47:0]             seg;
    logic [34:0]             sq_rem2, sq_trial;
    logic                    sq_last, emit;

    gctl_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (c_start),
        .vec_mode (c_vec),
        .angle    (c_angle),
        .vx       (w_reg),
        .vy       (m_reg),
        .done     (c_done),
        .x_out    (c_x),
        .y_out    (c_y),
        .z_out    (c_z)
    );

    assign c_start = (state_reg == S_CORD_GO) || (state_reg == S_VEC_GO);
    assign c_vec   = (state_reg == S_VEC_GO);

    always_comb
    begin
        case (cidx_reg)
            2'd0:    c_angle = ent_reg.lat_a;
            2'd1:    c_angle = ent_reg.lat_b;
            2'd2:    c_angle = ent_reg.dlat_half;
            default: c_angle = ent_reg.dlon_half;
        endcase
    end

    assign xr    = (c_x + HRND) >>> CORDIC_GUARD;
    assign yr    = (c_y + HRND) >>> CORDIC_GUARD;
    assign cos_c = (xr < 0) ? '0 : ((xr > ONE_X) ? 31'(ONE_X) : xr[30:0]);
    assign sin_c = (yr < -ONE_X) ? -32'(ONE_X) : ((yr > ONE_X) ? 32'(ONE_X) : yr[31:0]);
    assign z2    = {c_z, 1'b0};

    always_comb
    begin
        case (state_reg)
            S_MUL_CC:
            begin
                mul_a = {2'b0, ca_reg};
                mul_b = {2'b0, cb_reg};
            end
            S_MUL_V:
            begin
                mul_a = 33'(s2_reg);
                mul_b = {2'b0, g_reg};
            end
            S_MUL_S1:
            begin
                mul_a = 33'(s1_reg);
                mul_b = 33'(s1_reg);
            end
            S_MUL_VV:
            begin
                mul_a = 33'(v_reg);
                mul_b = 33'(v_reg);
            end
            S_MUL_AH:
            begin
                mul_a = {15'b0, ang_reg[35:18]};
                mul_b = {9'b0, radius_reg};
            end
            S_MUL_AL:
            begin
                mul_a = {15'b0, ang_reg[17:0]};
                mul_b = {9'b0, radius_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign vq    = (p_reg + 66'sd536870912) >>> 30;
    assign h_sum = h_reg + p_reg[61:0];
    assign seg   = 48'((prod_reg + RND) >> SH_OUT);

    assign sq_rem2  = {sq_rem_reg, sq_val_reg[61:60]};
    assign sq_trial = {2'b0, sq_root_reg, 2'b01};
    assign sq_last  = (sq_cnt_reg == CNT_W'(30));

    assign emit  = (state_reg == S_FIN) && ent_reg.last && (!out_valid_reg || pop);
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign empty        = !out_valid_reg;
    assign total_length = out_total_reg;
    assign saturated    = out_sat_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                    state_next = q_entry.has_seg ? S_CORD_GO : S_FIN;
            end
            S_CORD_GO:
            begin
                state_next = S_CORD_WT;
            end
            S_CORD_WT:
            begin
                if (c_done)
                    state_next = (cidx_reg == 2'd3) ? S_MUL_CC : S_CORD_GO;
            end
            S_MUL_CC:
            begin
                state_next = S_SQ_LOAD;
            end
            S_SQ_LOAD:
            begin
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN:
            begin
                if (sq_last)
                begin
                    case (sq_sel_reg)
                        SQ_G:    state_next = S_MUL_V;
                        SQ_M:    state_next = S_SQ_LOAD;
                        default: state_next = S_VEC_GO;
                    endcase
                end
            end
            S_MUL_V:
            begin
                state_next = S_V;
            end
            S_V:
            begin
                state_next = S_MUL_S1;
            end
            S_MUL_S1:
            begin
                state_next = S_MUL_VV;
            end
            S_MUL_VV:
            begin
                state_next = S_H_SUM;
            end
            S_H_SUM:
            begin
                state_next = S_SQ_LOAD;
            end
            S_VEC_GO:
            begin
                state_next = S_VEC_WT;
            end
            S_VEC_WT:
            begin
                if (c_done)
                    state_next = S_MUL_AH;
            end
            S_MUL_AH:
            begin
                state_next = S_MUL_AL;
            end
            S_MUL_AL:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ent_reg.last || emit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cidx_reg      <= '0;
            sq_sel_reg    <= SQ_G;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            radius_reg    <= RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                radius_reg <= cfg_wdata;

            if (q_pop)
            begin
                cidx_reg   <= '0;
                sq_sel_reg <= SQ_G;
                if (q_entry.first)
                begin
                    sum_reg <= '0;
                    sat_reg <= 1'b0;
                end
            end

            if ((state_reg == S_CORD_WT) && c_done)
                cidx_reg <= cidx_reg + 2'd1;

            if ((state_reg == S_SQ_RUN) && sq_last)
                sq_sel_reg <= (sq_sel_reg == SQ_G) ? SQ_M : SQ_W;

            if (state_reg == S_ACC)
            begin
                if (seg >= (MAX48 - sum_reg))
                begin
                    sum_reg <= MAX48;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_reg + seg;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                sat_reg       <= 1'b0;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;

        if (q_pop)
            ent_reg <= q_entry;

        if ((state_reg == S_CORD_WT) && c_done)
        begin
            case (cidx_reg)
                2'd0:    ca_reg <= cos_c;
                2'd1:    cb_reg <= cos_c;
                2'd2:    s1_reg <= sin_c;
                default: s2_reg <= sin_c;
            endcase
        end

        if (state_reg == S_SQ_LOAD)
        begin
            case (sq_sel_reg)
                SQ_G:    sq_val_reg <= p_reg[61:0];
                SQ_M:    sq_val_reg <= h_reg;
                default: sq_val_reg <= ONE60 - h_reg;
            endcase
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        else if (state_reg == S_SQ_RUN)
        begin
            sq_val_reg <= {sq_val_reg[59:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + CNT_W'(1);
            if (sq_rem2 >= sq_trial)
            begin
                sq_rem_reg  <= 33'(sq_rem2 - sq_trial);
                sq_root_reg <= {sq_root_reg[29:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= 33'(sq_rem2);
                sq_root_reg <= {sq_root_reg[29:0], 1'b0};
            end
            if (sq_last)
            begin
                case (sq_sel_reg)
                    SQ_G:    g_reg <= {sq_root_reg[29:0], sq_rem2 >= sq_trial};
                    SQ_M:    m_reg <= {sq_root_reg[29:0], sq_rem2 >= sq_trial};
                    default: w_reg <= {sq_root_reg[29:0], sq_rem2 >= sq_trial};
                endcase
            end
        end

        if (state_reg == S_V)
            v_reg <= vq[31:0];
        if (state_reg == S_MUL_VV)
            h_reg <= p_reg[61:0];
        if (state_reg == S_H_SUM)
            h_reg <= (h_sum > ONE60) ? ONE60 : h_sum;

        if ((state_reg == S_VEC_WT) && c_done)
            ang_reg <= z2[CZ_W] ? '0 : z2[35:0];

        if (state_reg == S_MUL_AL)
            prod_reg <= 62'({p_reg[41:0], 18'b0});
        if (state_reg == S_PROD)
            prod_reg <= prod_reg + 62'(p_reg[41:0]);

        if (emit)
        begin
            out_total_reg <= sum_reg;
            out_sat_reg   <= sat_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/great_circle_track_length_core.sv
// top level of the great circle track length core
// per point with a segment the back end runs five cordic passes, three square roots and a
//   chain of multiply, sum and accumulate steps; a point without a segment skips all of them
// throughput: one point per back-end pass; the front end takes no new point until it has
//   pushed the last one into the queue, and a two-entry queue lets it run ahead
// reset: clears the track state and the queue and empties the result register; radius goes to 6371109
`default_nettype none

module great_circle_track_length_core #(
    parameter int ANGLE_FRAC_BITS  = gctl_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int LENGTH_FRAC_BITS = gctl_pkg::LENGTH_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [30:0] lat_rad,
    input  wire logic signed [31:0] lon_rad,
    input  wire logic               track_start,
    input  wire logic               track_end,
    output logic                    empty,
    input  wire logic               pop,
    output logic [47:0]             total_length,
    output logic                    saturated,
    input  wire logic               cfg_we,
    input  wire logic [23:0]        cfg_wdata
);
    import gctl_pkg::*;

    logic        q_push, q_full, q_pop, q_empty;
    gctl_entry_t wr_entry, rd_entry;

    gctl_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .lat_rad     (lat_rad),
        .lon_rad     (lon_rad),
        .track_start (track_start),
        .track_end   (track_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (wr_entry)
    );

    gctl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_full   (q_full),
        .wr_entry (wr_entry),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .rd_entry (rd_entry)
    );

    gctl_back #(
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_entry      (rd_entry),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .empty        (empty),
        .pop          (pop),
        .total_length (total_length),
        .saturated    (saturated)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && saturated) |-> (total_length == MAX48))
        else $error("saturated transaction without a full-scale total");

endmodule

`default_nettype wire

### test/great_circle_track_length_core_test.sv
// testbench of the great circle track length core: table-driven directed points, then random tracks
`timescale 1ns / 100ps
`default_nettype none

module great_circle_track_length_core_test;

    localparam int  AFB         = 29;
    localparam int  LFB         = 8;
    localparam int  IDLE_MAX    = 12;
    localparam int  DOG_LIMIT   = 20000;
    localparam int  N_RANDOM    = 1500;
    localparam int  SETTLE      = 400;
    localparam logic signed [30:0] LAT_TOP = 31'sd843314857;
    localparam logic signed [31:0] LON_TOP = 32'sd1686629713;
    localparam logic [47:0] TOP48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic               first;
        logic               last;
    } point_t;

    typedef struct packed {
        logic [47:0] total;
        logic        sat;
    } track_total_t;

    typedef struct {
        point_t       pt;
        logic         known;
        track_total_t want;
    } table_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [30:0] lat_rad;
    logic signed [31:0] lon_rad;
    logic               track_start;
    logic               track_end;
    logic               empty;
    logic               pop;
    logic [47:0]        total_length;
    logic               saturated;
    logic               cfg_we;
    logic [23:0]        cfg_wdata;

    great_circle_track_length_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .lat_rad      (lat_rad),
        .lon_rad      (lon_rad),
        .track_start  (track_start),
        .track_end    (track_end),
        .empty        (empty),
        .pop          (pop),
        .total_length (total_length),
        .saturated    (saturated),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // predictor state
    longint       atan_q32[32];
    longint       radius;
    longint       last_lat;
    longint       last_lon;
    bit           last_valid;
    longint       run_sum;
    bit           run_sat;
    track_total_t totals_due[$];
    int           n_fail;
    int           n_sent;
    int           dog;
    bit           hold_off;
    bit           sending_done;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic build_atan();
        longint pi60;
        longint acc;
        longint term;
        int     sh;
        pi60 = 64'sh3243F6A8885A308D;
        atan_q32[0] = (pi60 + (64'sd1 << 29)) >>> 30;
        for (int i = 1; i < 32; i++)
        begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++)
            begin
                sh = i * (2 * k + 1);
                term = (64'sd1 << (62 - sh)) / (2 * k + 1);
                acc = (k & 1) ? acc - term : acc + term;
            end
            atan_q32[i] = (acc + (64'sd1 << 29)) >>> 30;
        end
    endtask

    function automatic void rotate(longint th, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = 64'sd652032874 << 16;
        y = 0;
        z = th;
        for (int i = 0; i < 32; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_q32[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_q32[i];
            end
        end
        c = fshr(x + (64'sd1 << 15), 16);
        s = fshr(y + (64'sd1 << 15), 16);
    endfunction

    function automatic longint vector_angle(longint xin, longint yin);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = xin << 16;
        y = yin << 16;
        z = 0;
        for (int i = 0; i < 32; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z = z + atan_q32[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atan_q32[i];
            end
        end
        return z;
    endfunction

    function automatic longint arc_length(longint lat_a, longint lon_a, longint lat_b,
                                          longint lon_b);
        longint one;
        longint pi32;
        longint half;
        longint la;
        longint lb;
        longint phi;
        longint r;
        longint ca;
        longint cb;
        longint s1;
        longint s2;
        longint dummy;
        longint g;
        longint v;
        longint h60;
        longint m;
        longint w;
        longint ang;
        longint unsigned prod;
        one = 64'sd1 << 30;
        pi32 = (64'sh3243F6A8885A308D + (64'sd1 << 27)) >>> 28;
        half = pi32 / 2;
        la = clampl(lat_a * (1 << (32 - AFB)), -half, half);
        lb = clampl(lat_b * (1 << (32 - AFB)), -half, half);
        phi = (lon_b * (1 << (32 - AFB)) - lon_a * (1 << (32 - AFB))) / 2;
        r = (phi + half) % pi32;
        if (r < 0)
            r = r + pi32;
        phi = r - half;
        rotate(la, ca, dummy);
        rotate(lb, cb, dummy);
        rotate((lb - la) / 2, dummy, s1);
        rotate(phi, dummy, s2);
        ca = clampl(ca, 0, one);
        cb = clampl(cb, 0, one);
        s1 = clampl(s1, -one, one);
        s2 = clampl(s2, -one, one);
        g = root_floor(ca * cb);
        v = fshr(s2 * g + (64'sd1 << 29), 30);
        h60 = s1 * s1 + v * v;
        if (h60 > one * one)
            h60 = one * one;
        m = root_floor(h60);
        w = root_floor(one * one - h60);
        ang = 2 * vector_angle(w, m);
        if (ang < 0)
            ang = 0;
        prod = longint'(ang) * radius;
        return longint'((prod + (64'd1 << (31 - LFB))) >> (32 - LFB));
    endfunction

    function automatic void track_point(point_t p);
        longint seg;
        track_total_t t;
        if (p.first)
        begin
            run_sum = 0;
            run_sat = 0;
            last_valid = 0;
        end
        if (last_valid)
        begin
            seg = arc_length(last_lat, last_lon, longint'(p.lat), longint'(p.lon));
            if (seg >= longint'(TOP48) - run_sum)
            begin
                run_sum = longint'(TOP48);
                run_sat = 1;
            end
            else
                run_sum = run_sum + seg;
        end
        last_lat = p.lat;
        last_lon = p.lon;
        last_valid = 1;
        if (p.last)
        begin
            t.total = run_sum[47:0];
            t.sat = run_sat;
            totals_due.push_back(t);
            run_sum = 0;
            run_sat = 0;
            last_valid = 0;
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // push stays high after the accepting edge until the next negedge decides
    task automatic send_point(point_t p);
        int idle;
        idle = $urandom_range(0, IDLE_MAX);
        @(negedge clk);
        if (idle != 0)
        begin
            push <= 0;
            repeat (idle) @(negedge clk);
        end
        push <= 1;
        lat_rad <= p.lat;
        lon_rad <= p.lon;
        track_start <= p.first;
        track_end <= p.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        track_point(p);
        n_sent++;
    endtask

    task automatic write_radius(logic [23:0] r);
        @(negedge clk);
        push <= 0;
        while (totals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we <= 0;
        radius = r;
    endtask

    function automatic point_t rand_point(bit first, bit last, bit wide);
        point_t p;
        if (wide)
        begin
            p.lat = 31'($urandom);
            p.lon = $urandom;
        end
        else
        begin
            p.lat = 31'($signed($urandom_range(0, 2 * 843314857)) - 843314857);
            p.lon = 32'(longint'($urandom_range(0, 32'hC90FDAA2)) - 64'sd1686629713);
        end
        p.first = first;
        p.last = last;
        return p;
    endfunction

    // directed table
    table_row_t plan[$];

    task automatic add_row(logic signed [30:0] la, logic signed [31:0] lo, bit f, bit l,
                           bit k, logic [47:0] tot, bit s);
        table_row_t row;
        row.pt = '{la, lo, f, l};
        row.known = k;
        row.want = '{tot, s};
        plan.push_back(row);
    endtask

    // result side
    initial
    begin
        track_total_t want;
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                pop <= 0;
                continue;
            end
            pop <= ($urandom_range(0, IDLE_MAX) == 0) || ($urandom_range(0, 3) == 0);
            @(posedge clk);
            if (pop && !empty)
            begin
                if (totals_due.size() == 0)
                begin
                    $display("%0t: unexpected transaction total %0d sat %0b", $time,
                             total_length, saturated);
                    n_fail++;
                end
                else
                begin
                    want = totals_due.pop_front();
                    if (total_length !== want.total)
                    begin
                        $display("%0t: total_length expected %0d actual %0d", $time,
                                 want.total, total_length);
                        n_fail++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 want.sat, saturated);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        dog = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || hold_off
                || sending_done && totals_due.size() == 0)
                dog = 0;
            else
                dog++;
            if (dog >= DOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        point_t p;
        int     len;
        table_row_t row;
        build_atan();
        n_fail = 0;
        n_sent = 0;
        hold_off = 0;
        sending_done = 0;
        radius = 6371109;
        run_sum = 0;
        run_sat = 0;
        last_valid = 0;
        rst_n = 0;
        push = 0;
        lat_rad = '0;
        lon_rad = '0;
        track_start = 0;
        track_end = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // one-point track, no segment
        add_row(31'sd0, 32'sd0, 1, 1, 1, 48'd0, 0);
        // same point twice
        add_row(LAT_TOP, LON_TOP, 1, 0, 0, 48'd0, 0);
        add_row(LAT_TOP, LON_TOP, 0, 1, 0, 48'd0, 0);
        // extremes and out-of-range latitude
        add_row(-LAT_TOP, -LON_TOP, 1, 0, 0, 48'd0, 0);
        add_row(LAT_TOP, LON_TOP, 0, 0, 0, 48'd0, 0);
        add_row(31'h3FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 48'd0, 0);
        add_row(31'h4000_0000, 32'h8000_0000, 0, 1, 0, 48'd0, 0);
        // points with no start mark, antipodal longitude
        add_row(31'sd0, 32'sd0, 0, 0, 0, 48'd0, 0);
        add_row(31'sd0, 32'sd1686629713, 0, 0, 0, 48'd0, 0);
        add_row(31'sd0, -32'sd1686629713, 0, 1, 0, 48'd0, 0);
        // start mark mid-track drops the sum
        add_row(31'sd1000, 32'sd5000, 0, 0, 0, 48'd0, 0);
        add_row(31'sd2000, -32'sd5000, 1, 0, 0, 48'd0, 0);
        add_row(-31'sd7777, 32'sd123456, 0, 1, 0, 48'd0, 0);
        foreach (plan[i])
        begin
            row = plan[i];
            send_point(row.pt);
            if (row.known && (totals_due.size() == 0 || totals_due[$] !== row.want))
            begin
                $display("%0t: table row %0d predicted %0d", $time, i, totals_due[$].total);
                n_fail++;
            end
        end

        // radius settings: extremes and zero
        write_radius(24'hFFFFFF);
        for (int t = 0; t < 3; t++)
        begin
            send_point(rand_point(1, 0, 0));
            repeat (4) send_point(rand_point(0, 0, 0));
            send_point(rand_point(0, 1, 0));
        end
        write_radius(24'd1);
        send_point(rand_point(1, 0, 0));
        send_point(rand_point(0, 1, 0));
        write_radius(24'd0);
        send_point(rand_point(1, 0, 0));
        send_point(rand_point(0, 1, 0));
        write_radius(24'hFFFFFF);
        // long track of half-circle hops at the largest radius
        send_point('{31'sd0, 32'sd0, 1'b1, 1'b0});
        for (int k = 0; k < 70; k++)
            send_point('{31'sd0, (k % 2) ? 32'sd0 : LON_TOP, 1'b0, 1'b0});
        send_point('{31'sd0, 32'sd0, 1'b0, 1'b1});

        // receiver holds off so the queue backs up
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            for (int k = 0; k < 8; k++)
                send_point(rand_point(1, 1, 0));
        join

        write_radius(24'd6371109);
        while (n_sent < N_RANDOM)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_point(rand_point($urandom_range(0, 1), $urandom_range(0, 1), 1));
                continue;
            end
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                p = rand_point(k == 0, k == len - 1, $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) == 0 && k > 0)
                begin
                    p.lat = 31'(last_lat + $signed($urandom_range(0, 2000)) - 1000);
                    p.lon = 32'(last_lon + $signed($urandom_range(0, 2000)) - 1000);
                end
                send_point(p);
            end
            if (n_sent > N_RANDOM / 2 && radius == 6371109)
                write_radius($urandom_range(1, 24'hFFFFFE));
        end
        send_point(rand_point(0, 1, 0));
        @(negedge clk);
        push <= 0;
        sending_done = 1;

        while (totals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/gctl_pkg.sv
hw/rtl/gctl_front.sv
hw/rtl/gctl_queue.sv
hw/rtl/gctl_cordic.sv
hw/rtl/gctl_back.sv
hw/rtl/great_circle_track_length_core.sv
test/great_circle_track_length_core_test.sv
